>>> hw/rtl/mck_pkg.sv
// Package for the Morse character keyer: shared types, segment constants
// and the symbol table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mck_pkg;

  // Widths of the symbol table entries, of the table index and of the dot counts.
  localparam int unsigned SymBitsW = 6;
  localparam int unsigned SymLenW  = 3;
  localparam int unsigned SymIdxW  = 6;
  localparam int unsigned DotsW    = 2;

  // Segment lengths in dot units.
  localparam logic [DotsW-1:0] DOTS_DOT   = 2'd1;
  localparam logic [DotsW-1:0] DOTS_DASH  = 2'd3;
  localparam logic [DotsW-1:0] DOTS_PAUSE = 2'd1;
  localparam logic [DotsW-1:0] DOTS_GAP   = 2'd2;

  // Character codes with special meaning.
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_PERIOD = 8'h2E;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

  // Table index bases.
  localparam logic [SymIdxW-1:0] IDX_PERIOD = 6'd0;
  localparam logic [SymIdxW-1:0] IDX_COMMA  = 6'd1;
  localparam logic [SymIdxW-1:0] IDX_DIGIT  = 6'd2;
  localparam logic [SymIdxW-1:0] IDX_LETTER = 6'd12;

  // Decoded symbol: element bits (1 = dash, MSB-aligned to the element
  // count), element count (zero when there is no symbol) and a space flag.
  typedef struct packed {
    logic [SymBitsW-1:0] bits;
    logic [SymLenW-1:0]  len;
    logic                is_space;
  } sym_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_PAUSE,
    ST_SPACE,
    ST_GAP
  } state_t;

  // Element bits and count for each table index, packed as {bits, len}.
  function automatic logic [SymBitsW+SymLenW-1:0] sym_entry(
    input logic [SymIdxW-1:0] idx
  );
    logic [SymBitsW+SymLenW-1:0] e;
    case (idx)
      6'd0:  e = {6'h15, 3'd6};
      6'd1:  e = {6'h33, 3'd6};
      6'd2:  e = {6'h1F, 3'd5};
      6'd3:  e = {6'h0F, 3'd5};
      6'd4:  e = {6'h07, 3'd5};
      6'd5:  e = {6'h03, 3'd5};
      6'd6:  e = {6'h01, 3'd5};
      6'd7:  e = {6'h00, 3'd5};
      6'd8:  e = {6'h10, 3'd5};
      6'd9:  e = {6'h18, 3'd5};
      6'd10: e = {6'h1C, 3'd5};
      6'd11: e = {6'h1E, 3'd5};
      6'd12: e = {6'h01, 3'd2};
      6'd13: e = {6'h08, 3'd4};
      6'd14: e = {6'h0A, 3'd4};
      6'd15: e = {6'h04, 3'd3};
      6'd16: e = {6'h00, 3'd1};
      6'd17: e = {6'h02, 3'd4};
      6'd18: e = {6'h06, 3'd3};
      6'd19: e = {6'h00, 3'd4};
      6'd20: e = {6'h00, 3'd2};
      6'd21: e = {6'h07, 3'd4};
      6'd22: e = {6'h05, 3'd3};
      6'd23: e = {6'h04, 3'd4};
      6'd24: e = {6'h03, 3'd2};
      6'd25: e = {6'h02, 3'd2};
      6'd26: e = {6'h07, 3'd3};
      6'd27: e = {6'h06, 3'd4};
      6'd28: e = {6'h0D, 3'd4};
      6'd29: e = {6'h02, 3'd3};
      6'd30: e = {6'h00, 3'd3};
      6'd31: e = {6'h01, 3'd1};
      6'd32: e = {6'h01, 3'd3};
      6'd33: e = {6'h01, 3'd4};
      6'd34: e = {6'h03, 3'd3};
      6'd35: e = {6'h09, 3'd4};
      6'd36: e = {6'h0B, 3'd4};
      6'd37: e = {6'h0C, 3'd4};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage : mck_pkg

`default_nettype wire

>>> hw/rtl/morse_character_keyer_core.sv
// Top level of the Morse character keyer: input handshake, element
// sequencer and output register. Depends on mck_pkg and mck_lookup.
//
//   Channel  | Direction | Ports
//   ---------+-----------+------------------------------------------------
//   in       | input     | in_valid, in_ready, in_character
//   out      | output    | out_valid, out_ready, out_key_on,
//            |           | out_duration_dots, out_last
//
// A character with n elements yields 2n+1 segments (a space yields two,
// an unsupported code one). The sequencer loads one segment into the output
// register per cycle while that register is free; in_ready is high only
// while idle. Output stalls hold the sequencer. Reset clears the state and
// out_valid.
`timescale 1ns / 1ps
`default_nettype none

module morse_character_keyer_core
  import mck_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_character,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_key_on,
  output logic [DotsW-1:0]      out_duration_dots,
  output logic                  out_last
);

  state_t              state_r, state_nxt;
  logic [SymBitsW-1:0] bits_r, bits_nxt;
  logic [SymLenW-1:0]  cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                key_r, key_nxt;
  logic [DotsW-1:0]    dots_r, dots_nxt;
  logic                last_r, last_nxt;
  sym_t                sym;
  logic                in_xfer;
  logic                out_free;

  // Symbol decode of the offered character.
  mck_lookup u_lookup (
    .character (in_character),
    .sym       (sym)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Sequencer: one segment per cycle whenever the output register is free.
  always_comb begin
    state_nxt     = state_r;
    bits_nxt      = bits_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    key_nxt       = key_r;
    dots_nxt      = dots_r;
    last_nxt      = last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          bits_nxt = sym.bits;
          cnt_nxt  = sym.len;
          if (sym.is_space) begin
            state_nxt = ST_SPACE;
          end else if (sym.len == '0) begin
            state_nxt = ST_GAP;
          end else begin
            state_nxt = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          key_nxt       = 1'b1;
          dots_nxt      = bits_r[SymBitsW-1] ? DOTS_DASH : DOTS_DOT;
          last_nxt      = 1'b0;
          state_nxt     = ST_PAUSE;
        end
      end
      ST_PAUSE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          key_nxt       = 1'b0;
          dots_nxt      = DOTS_PAUSE;
          last_nxt      = 1'b0;
          bits_nxt      = bits_r << 1;
          cnt_nxt       = cnt_r - SymLenW'(1);
          state_nxt     = (cnt_r == SymLenW'(1)) ? ST_GAP : ST_MARK;
        end
      end
      ST_SPACE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          key_nxt       = 1'b0;
          dots_nxt      = DOTS_GAP;
          last_nxt      = 1'b0;
          state_nxt     = ST_GAP;
        end
      end
      ST_GAP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          key_nxt       = 1'b0;
          dots_nxt      = DOTS_GAP;
          last_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
    cnt_r  <= cnt_nxt;
    key_r  <= key_nxt;
    dots_r <= dots_nxt;
    last_r <= last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_key_on        = key_r;
  assign out_duration_dots = dots_r;
  assign out_last          = last_r;

endmodule : morse_character_keyer_core

`default_nettype wire

>>> hw/rtl/mck_lookup.sv
// Character decoder: maps an ASCII code to its Morse symbol entry.
// Depends on mck_pkg for the symbol table and the sym_t type.
`timescale 1ns / 1ps
`default_nettype none

module mck_lookup
  import mck_pkg::*;
(
  input  wire logic [7:0] character,
  output sym_t            sym
);

  logic                        hit;
  logic [SymIdxW-1:0]          idx;
  logic [SymBitsW+SymLenW-1:0] entry;
  logic [SymBitsW-1:0]         raw_bits;
  logic [SymLenW-1:0]          raw_len;

  // Work out the table index; characters without a symbol get no hit.
  always_comb begin
    hit = 1'b1;
    idx = '0;
    if (character == CHAR_PERIOD) begin
      idx = IDX_PERIOD;
    end else if (character == CHAR_COMMA) begin
      idx = IDX_COMMA;
    end else if (character >= CHAR_ZERO && character <= CHAR_NINE) begin
      idx = IDX_DIGIT + SymIdxW'(character - CHAR_ZERO);
    end else if (character >= CHAR_UPPER_A && character <= CHAR_UPPER_Z) begin
      idx = IDX_LETTER + SymIdxW'(character - CHAR_UPPER_A);
    end else begin
      hit = 1'b0;
    end
  end

  assign entry    = sym_entry(idx);
  assign raw_bits = entry[SymBitsW+SymLenW-1:SymLenW];
  assign raw_len  = hit ? entry[SymLenW-1:0] : '0;

  // Align the first element to the top bit so the sequencer just shifts.
  always_comb begin
    sym.bits     = raw_bits << (3'(SymBitsW) - raw_len);
    sym.len      = raw_len;
    sym.is_space = (character == CHAR_SPACE);
  end

endmodule : mck_lookup

`default_nettype wire

>>> bench/tb_top.sv
// Testbench for morse_character_keyer_core: sends ASCII characters and checks every
// key segment against a Morse predictor built into the bench. Depends on mck_pkg and the core.
`timescale 1ns / 1ps

module tb_top;
  import mck_pkg::*;

  // Segment lengths in dot units, as the keying rules define them.
  localparam logic [DotsW-1:0] MARK_DASH_DOTS = 2'd3;
  localparam logic [DotsW-1:0] MARK_DOT_DOTS  = 2'd1;
  localparam logic [DotsW-1:0] PAUSE_LEN_DOTS = 2'd1;
  localparam logic [DotsW-1:0] GAP_LEN_DOTS   = 2'd2;
  localparam logic [7:0]       ASCII_SPACE    = 8'h20;
  localparam logic [7:0]       ASCII_PERIOD   = 8'h2E;
  localparam logic [7:0]       ASCII_COMMA    = 8'h2C;
  localparam logic [7:0]       ASCII_DIGIT0   = 8'h30;
  localparam logic [7:0]       ASCII_LETTER_A = 8'h41;
  localparam int               CYCLE_LIMIT    = 200000;
  localparam int               TAIL_CYCLES    = 20;

  typedef struct packed {
    logic             key_on;
    logic [DotsW-1:0] dots;
    logic             last;
  } segment_t;

  typedef struct {
    logic [7:0] ch;
    bit         drain;
  } char_item_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_character = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_key_on;
  logic [DotsW-1:0] out_duration_dots;
  logic             out_last;

  char_item_t char_queue[$];
  segment_t   expected_segs[$];
  int         total_items = 0;
  int         accepted_count = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;

  morse_character_keyer_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_character     (in_character),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_key_on       (out_key_on),
    .out_duration_dots(out_duration_dots),
    .out_last         (out_last)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Standard Morse pattern of a character; empty when it has no symbol.
  function automatic string morse_pattern(input logic [7:0] ch);
    case (ch)
      ".": return ".-.-.-";
      ",": return "--..--";
      "0": return "-----";
      "1": return ".----";
      "2": return "..---";
      "3": return "...--";
      "4": return "....-";
      "5": return ".....";
      "6": return "-....";
      "7": return "--...";
      "8": return "---..";
      "9": return "----.";
      "A": return ".-";
      "B": return "-...";
      "C": return "-.-.";
      "D": return "-..";
      "E": return ".";
      "F": return "..-.";
      "G": return "--.";
      "H": return "....";
      "I": return "..";
      "J": return ".---";
      "K": return "-.-";
      "L": return ".-..";
      "M": return "--";
      "N": return "-.";
      "O": return "---";
      "P": return ".--.";
      "Q": return "--.-";
      "R": return ".-.";
      "S": return "...";
      "T": return "-";
      "U": return "..-";
      "V": return "...-";
      "W": return ".--";
      "X": return "-..-";
      "Y": return "-.--";
      "Z": return "--..";
      default: return "";
    endcase
  endfunction

  // Queue the key segments that one character should produce.
  task automatic predict_segments(input logic [7:0] ch);
    string    pattern;
    segment_t seg;
    pattern = morse_pattern(ch);
    if (ch == ASCII_SPACE) begin
      seg = '{key_on: 1'b0, dots: GAP_LEN_DOTS, last: 1'b0};
      expected_segs.push_back(seg);
    end
    for (int i = 0; i < pattern.len(); i++) begin
      seg = '{key_on: 1'b1, dots: (pattern[i] == "-") ? MARK_DASH_DOTS : MARK_DOT_DOTS,
              last: 1'b0};
      expected_segs.push_back(seg);
      seg = '{key_on: 1'b0, dots: PAUSE_LEN_DOTS, last: 1'b0};
      expected_segs.push_back(seg);
    end
    seg = '{key_on: 1'b0, dots: GAP_LEN_DOTS, last: 1'b1};
    expected_segs.push_back(seg);
  endtask

  // Idling phase follows progress: sender light and receiver heavy, then the
  // reverse, then no idling at all.
  function automatic int idle_phase(input int done);
    if (done < total_items / 3) begin
      return 0;
    end else if (done < (2 * total_items) / 3) begin
      return 1;
    end
    return 2;
  endfunction

  function automatic int sender_idle_pct(input int done);
    case (idle_phase(done))
      0: return 21;
      1: return 67;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct(input int done);
    case (idle_phase(done))
      0: return 67;
      1: return 21;
      default: return 0;
    endcase
  endfunction

  task automatic add_char(input logic [7:0] ch, input bit drain);
    char_item_t item;
    item.ch = ch;
    item.drain = drain;
    char_queue.push_back(item);
  endtask

  // A character that has a Morse symbol, picked uniformly.
  function automatic logic [7:0] random_symbol_char();
    int k;
    k = $urandom_range(0, 37);
    if (k == 0) begin
      return ASCII_PERIOD;
    end else if (k == 1) begin
      return ASCII_COMMA;
    end else if (k < 12) begin
      return ASCII_DIGIT0 + 8'(k - 2);
    end
    return ASCII_LETTER_A + 8'(k - 12);
  endfunction

  // Input driver: predicts each accepted transfer and presents the next character.
  always @(posedge clk) begin : char_driver
    char_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_segments(in_character);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (char_queue.size() != 0 &&
            $urandom_range(0, 99) >= sender_idle_pct(accepted_count) &&
            !(char_queue[0].drain && expected_segs.size() != 0)) begin
          nxt = char_queue.pop_front();
          in_valid <= 1'b1;
          in_character <= nxt.ch;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compares each segment transfer with the oldest expectation.
  always @(posedge clk) begin : segment_monitor
    segment_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_segs.size() == 0) begin
          $error("unexpected segment: key_on %0d, duration_dots %0d, last %0d",
                 out_key_on, out_duration_dots, out_last);
          mismatch_count++;
        end else begin
          want = expected_segs.pop_front();
          if (out_key_on !== want.key_on) begin
            $error("key_on: expected %0d, got %0d", want.key_on, out_key_on);
            mismatch_count++;
          end
          if (out_duration_dots !== want.dots) begin
            $error("duration_dots: expected %0d, got %0d", want.dots, out_duration_dots);
            mismatch_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            mismatch_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct(accepted_count));
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int pick;
    // Directed characters: longest symbols, digit and letter extremes, the
    // single-element letters, space and unsupported codes of every kind.
    add_char(".", 1'b0);
    add_char(",", 1'b0);
    add_char("0", 1'b0);
    add_char("9", 1'b0);
    add_char("5", 1'b0);
    add_char("1", 1'b0);
    add_char("A", 1'b0);
    add_char("Z", 1'b0);
    add_char("E", 1'b0);
    add_char("T", 1'b0);
    add_char("H", 1'b0);
    add_char("Q", 1'b0);
    add_char(ASCII_SPACE, 1'b0);
    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b0);
    add_char(8'h80, 1'b0);
    add_char(8'h7F, 1'b0);
    add_char("a", 1'b0);
    add_char("z", 1'b0);
    add_char("/", 1'b0);
    add_char(":", 1'b0);
    add_char("@", 1'b0);
    add_char("[", 1'b0);
    add_char("-", 1'b1);

    // Random characters, mostly ones with a symbol; the odd one waits for
    // the output to drain before it is offered.
    for (int i = 0; i < 446; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        add_char(random_symbol_char(), ($urandom_range(0, 49) == 0));
      end else if (pick < 80) begin
        add_char(ASCII_SPACE, 1'b0);
      end else begin
        add_char(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    total_items = char_queue.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total_items) @(posedge clk);
    while (expected_segs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_segs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
